// ===== design/adc_channel_calibrate_average_top_defines.svh =====
// Assertion macros for the converter channel calibrate-and-average block.
// Used by adc_channel_calibrate_average_top; needs clk and rst_n in scope.
`ifndef ADC_CHANNEL_CALIBRATE_AVERAGE_TOP_DEFINES_SVH
`define ADC_CHANNEL_CALIBRATE_AVERAGE_TOP_DEFINES_SVH

// Implication checked on every rising edge while out of reset.
`define ADCCA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adcca: implication check failed");

// Condition that must hold in the cycle after reset is applied.
`define ADCCA_ASSERT_AFTER_RESET(label, cond) \
  label: assert property (@(posedge clk) !rst_n |=> (cond)) \
    else $error("adcca: post-reset check failed");

`endif

// ===== design/adcca_pkg.sv =====
// Shared types, constants and saturation helper for the channel calibrate-and-average block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adcca_pkg;

  localparam int DATA_W     = 32;
  localparam int CODE_W     = 16;
  localparam int CHAN_W     = 3;
  localparam int WIDE_W     = 66;
  localparam int VOLT_SHIFT = 6;
  localparam int PHY_SHIFT  = 24;

  localparam logic signed [WIDE_W-1:0] SAT_MAX   = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN   = -66'sd2147483648;
  localparam logic signed [WIDE_W-1:0] VOLT_HALF = 66'sd1 <<< (VOLT_SHIFT - 1);
  localparam logic signed [WIDE_W-1:0] PHY_HALF  = 66'sd1 <<< (PHY_SHIFT - 1);

  typedef struct packed {
    logic [CHAN_W-1:0]        channel;
    logic                     in_range;
    logic signed [DATA_W-1:0] sample;
    logic                     phy_enable;
    logic signed [DATA_W-1:0] phy_gain;
    logic signed [DATA_W-1:0] phy_offset;
  } job_t;

  typedef struct packed {
    logic [CHAN_W-1:0]        channel;
    logic signed [DATA_W-1:0] avg_voltage;
    logic signed [DATA_W-1:0] phy_value;
    logic                     phy_valid;
  } result_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[DATA_W-1:0];
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/adc_channel_calibrate_average_top.sv =====
// Top level of the converter channel calibrate-and-average block.
// Depends on adcca_pkg, adcca_front, adcca_queue, adcca_back and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "adc_channel_calibrate_average_top_defines.svh"

// Each transaction carries one raw converter code; the block returns one result per
// transaction, in order. The front scales the code to a Q8.24 voltage and hands it
// through a two-entry queue to the back sequencer, which handles one item at a time. For
// a primed channel the back does the pickup from the queue, one state memory read, one
// window memory read, the running-sum update, the division by the window depth with a
// reciprocal multiply split in two halves, the physical multiply and the result handoff.
// An unprimed channel with conversion enabled first fills the window, one window memory
// write per cycle; every other item goes from the pickup to the physical multiply and the
// handoff. Results wait in a two-entry output queue. The window memory needs no clearing
// after reset, so the block accepts transactions from the first cycle.
module adc_channel_calibrate_average_top #(
  parameter int NUM_CHANNELS = 8,
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [adcca_pkg::CHAN_W-1:0]        in_channel,
  input  logic [adcca_pkg::CODE_W-1:0]        in_raw_code,
  input  logic                                in_bipolar,
  input  logic signed [adcca_pkg::DATA_W-1:0] in_volt_gain,
  input  logic signed [adcca_pkg::DATA_W-1:0] in_volt_offset,
  input  logic                                in_phy_enable,
  input  logic signed [adcca_pkg::DATA_W-1:0] in_phy_gain,
  input  logic signed [adcca_pkg::DATA_W-1:0] in_phy_offset,
  output logic                                empty,
  input  logic                                pop,
  output logic [adcca_pkg::CHAN_W-1:0]        out_channel,
  output logic signed [adcca_pkg::DATA_W-1:0] out_avg_voltage,
  output logic signed [adcca_pkg::DATA_W-1:0] out_phy_value,
  output logic                                out_phy_valid
);

  localparam int JOB_W = $bits(adcca_pkg::job_t);
  localparam int RES_W = $bits(adcca_pkg::result_t);

  adcca_pkg::job_t    front_job;
  adcca_pkg::job_t    back_job;
  adcca_pkg::result_t back_res;
  adcca_pkg::result_t out_res;
  logic [JOB_W-1:0]   job_vec;
  logic [RES_W-1:0]   res_vec;
  logic               job_push;
  logic               job_full;
  logic               job_pop;
  logic               job_empty;
  logic               res_push;
  logic               res_full;

  adcca_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_channel    (in_channel),
    .in_raw_code   (in_raw_code),
    .in_bipolar    (in_bipolar),
    .in_volt_gain  (in_volt_gain),
    .in_volt_offset(in_volt_offset),
    .in_phy_enable (in_phy_enable),
    .in_phy_gain   (in_phy_gain),
    .in_phy_offset (in_phy_offset),
    .job_push      (job_push),
    .job           (front_job),
    .job_full      (job_full)
  );

  adcca_queue #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_job_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(front_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_data (job_vec),
    .empty    (job_empty)
  );

  assign back_job = job_vec;

  adcca_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(job_empty),
    .job      (back_job),
    .job_pop  (job_pop),
    .res_push (res_push),
    .res      (back_res),
    .res_full (res_full)
  );

  adcca_queue #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(back_res),
    .full     (res_full),
    .pop      (pop),
    .pop_data (res_vec),
    .empty    (empty)
  );

  assign out_res         = res_vec;
  assign out_channel     = out_res.channel;
  assign out_avg_voltage = out_res.avg_voltage;
  assign out_phy_value   = out_res.phy_value;
  assign out_phy_valid   = out_res.phy_valid;

  `ADCCA_ASSERT_IMPLY(a_res_no_overflow, res_push, !res_full)
  `ADCCA_ASSERT_IMPLY(a_job_no_underflow, job_pop, !job_empty)
  `ADCCA_ASSERT_IMPLY(a_phy_zero_when_off, !empty && !out_phy_valid, out_phy_value == '0)
  `ADCCA_ASSERT_AFTER_RESET(a_reset_clears, empty && !full)

endmodule

`default_nettype wire

// ===== design/adcca_queue.sv =====
// Small first-in first-out queue of register entries.
// Standalone; used between front and back and on the result side.
`timescale 1ns / 1ps
`default_nettype none

module adcca_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/adcca_front.sv =====
// Front stage: accepts input transactions, scales the raw code to volts and classifies the channel.
// Depends on adcca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adcca_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic [adcca_pkg::CHAN_W-1:0]           in_channel,
  input  logic [adcca_pkg::CODE_W-1:0]           in_raw_code,
  input  logic                                   in_bipolar,
  input  logic signed [adcca_pkg::DATA_W-1:0]    in_volt_gain,
  input  logic signed [adcca_pkg::DATA_W-1:0]    in_volt_offset,
  input  logic                                   in_phy_enable,
  input  logic signed [adcca_pkg::DATA_W-1:0]    in_phy_gain,
  input  logic signed [adcca_pkg::DATA_W-1:0]    in_phy_offset,
  output logic                                   job_push,
  output adcca_pkg::job_t                        job,
  input  logic                                   job_full
);

  localparam int PROD_W = adcca_pkg::CODE_W + 1 + adcca_pkg::DATA_W;

  logic                                valid_r;
  logic signed [PROD_W-1:0]            prod_r;
  logic signed [adcca_pkg::DATA_W-1:0] voff_r;
  logic [adcca_pkg::CHAN_W-1:0]        chan_r;
  logic                                in_range_r;
  logic                                phy_en_r;
  logic signed [adcca_pkg::DATA_W-1:0] pgain_r;
  logic signed [adcca_pkg::DATA_W-1:0] poff_r;

  logic signed [adcca_pkg::CODE_W:0]   code;
  logic signed [PROD_W-1:0]            prod_nxt;
  logic                                load;
  logic signed [adcca_pkg::WIDE_W-1:0] volt_wide;

  assign code = (in_bipolar && in_raw_code[adcca_pkg::CODE_W-1]) ?
                $signed({1'b1, in_raw_code}) : $signed({1'b0, in_raw_code});
  assign prod_nxt = code * in_volt_gain;

  assign load     = push && !full;
  assign full     = valid_r && job_full;
  assign job_push = valid_r;

  assign volt_wide = ((adcca_pkg::WIDE_W'(prod_r) + adcca_pkg::VOLT_HALF)
                      >>> adcca_pkg::VOLT_SHIFT) + adcca_pkg::WIDE_W'(voff_r);

  always_comb begin
    job.channel    = chan_r;
    job.in_range   = in_range_r;
    job.sample     = adcca_pkg::sat32(volt_wide);
    job.phy_enable = phy_en_r;
    job.phy_gain   = pgain_r;
    job.phy_offset = poff_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!job_full) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r     <= prod_nxt;
      voff_r     <= in_volt_offset;
      chan_r     <= in_channel;
      in_range_r <= (32'(in_channel) < NUM_CHANNELS);
      phy_en_r   <= in_phy_enable;
      pgain_r    <= in_phy_gain;
      poff_r     <= in_phy_offset;
    end
  end

endmodule

`default_nettype wire

// ===== design/adcca_back.sv =====
// Back stage: window memory, running sums, division by the window depth and physical conversion.
// Depends on adcca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adcca_back #(
  parameter int NUM_CHANNELS = 8,
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  adcca_pkg::job_t     job,
  output logic                job_pop,
  output logic                res_push,
  output adcca_pkg::result_t  res,
  input  logic                res_full
);

  localparam int DW       = adcca_pkg::DATA_W;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W    = $clog2(WINDOW_DEPTH);
  localparam int ADDR_W   = $clog2(NUM_CHANNELS * WINDOW_DEPTH);
  localparam int LOG_W    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W    = DW + LOG_W;
  localparam int ST_W     = PTR_W + SUM_W;
  localparam int UN_W     = SUM_W - 1;
  localparam int LO_W     = UN_W / 2;
  localparam int HI_W     = UN_W - LO_W;
  localparam int RCP_W    = SUM_W;
  localparam int RCP_SH   = UN_W + LOG_W;
  localparam int ACC_W    = UN_W + RCP_W;
  localparam int DIV_CYC  = 3;
  localparam int CNT_MAX  = (DIV_CYC > WINDOW_DEPTH) ? DIV_CYC : WINDOW_DEPTH;
  localparam int CNT_W    = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

  // The rounded average is floor((sum + WINDOW_DEPTH / 2) / WINDOW_DEPTH); the reciprocal
  // is exact for every magnitude that fits in UN_W bits.
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH));

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_PTR  = 8'b0000_0100,
    ST_UPD  = 8'b0000_1000,
    ST_FILL = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t                     state_r;
  adcca_pkg::job_t            job_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [UN_W-1:0]            u_r;
  logic [ACC_W-1:0]           acc_r;
  logic                       neg_r;
  logic signed [DW-1:0]       avg_r;
  logic signed [2*DW-1:0]     prod_r;
  logic [NUM_CHANNELS-1:0]    primed_r;
  logic [ST_W-1:0]            st_rdata_r;
  logic signed [DW-1:0]       win_rdata_r;
  logic [ST_W-1:0]            st_mem_r [NUM_CHANNELS];
  logic signed [DW-1:0]       win_mem_r [NUM_CHANNELS * WINDOW_DEPTH];

  logic [CH_IDX_W-1:0]        job_idx;
  logic [CH_IDX_W-1:0]        in_idx;
  logic [ADDR_W-1:0]          base;
  logic [PTR_W-1:0]           st_ptr;
  logic [PTR_W-1:0]           ptr_nxt;
  logic signed [SUM_W-1:0]    st_sum;
  logic signed [SUM_W-1:0]    upd_sum;
  logic signed [SUM_W-1:0]    fill_sum;
  logic signed [SUM_W-1:0]    sample_x;
  logic signed [SUM_W-1:0]    t_val;
  logic [UN_W-1:0]            u_val;
  logic [HI_W-1:0]            mul_op;
  logic [HI_W+RCP_W-1:0]      mul_p;
  logic [ACC_W-1:0]           acc_nxt;
  logic [DW-1:0]              quo;
  logic [ADDR_W-1:0]          win_addr;
  logic                       win_we;
  logic                       win_re;
  logic                       st_we;
  logic                       st_re;
  logic [ST_W-1:0]            st_wdata;
  logic                       fill_last;
  logic                       div_last;
  logic signed [adcca_pkg::WIDE_W-1:0] phy_wide;

  assign job_idx  = CH_IDX_W'(job_r.channel);
  assign in_idx   = CH_IDX_W'(job.channel);
  assign base     = ADDR_W'(job_idx * WINDOW_DEPTH);
  assign st_ptr   = st_rdata_r[ST_W-1 -: PTR_W];
  assign st_sum   = $signed(st_rdata_r[SUM_W-1:0]);
  assign ptr_nxt  = (st_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : st_ptr + 1'b1;
  assign sample_x = SUM_W'(job_r.sample);
  assign upd_sum  = st_sum - SUM_W'(win_rdata_r) + sample_x;
  assign fill_sum = sum_r + sample_x;
  assign t_val    = upd_sum + SUM_W'(WINDOW_DEPTH / 2);
  assign u_val    = t_val[SUM_W-1] ? ~t_val[UN_W-1:0] : t_val[UN_W-1:0];

  assign mul_op   = (cnt_r == '0) ? HI_W'(u_r[LO_W-1:0]) : u_r[UN_W-1:LO_W];
  assign mul_p    = mul_op * RECIP;
  assign acc_nxt  = (cnt_r == '0) ? ACC_W'(mul_p) : acc_r + (ACC_W'(mul_p) << LO_W);
  assign quo      = acc_r[RCP_SH +: DW];

  assign fill_last = (cnt_r == CNT_W'(WINDOW_DEPTH - 1));
  assign div_last  = (cnt_r == CNT_W'(DIV_CYC - 1));

  assign job_pop  = (state_r == ST_IDLE) && !job_empty;
  assign res_push = (state_r == ST_OUT) && !res_full;

  always_comb begin
    win_we   = 1'b0;
    win_re   = 1'b0;
    st_we    = 1'b0;
    st_re    = 1'b0;
    win_addr = base + ADDR_W'(st_ptr);
    st_wdata = {ptr_nxt, upd_sum};
    case (state_r)
      ST_LOAD: st_re = 1'b1;
      ST_PTR:  win_re = 1'b1;
      ST_UPD: begin
        win_we = 1'b1;
        st_we  = 1'b1;
      end
      ST_FILL: begin
        win_addr = base + ADDR_W'(cnt_r);
        win_we   = 1'b1;
        st_we    = fill_last;
        st_wdata = {PTR_W'(0), fill_sum};
      end
      default: begin
      end
    endcase
  end

  assign phy_wide = ((adcca_pkg::WIDE_W'(prod_r) + adcca_pkg::PHY_HALF)
                     >>> adcca_pkg::PHY_SHIFT) + adcca_pkg::WIDE_W'(job_r.phy_offset);

  always_comb begin
    res.channel     = job_r.channel;
    res.avg_voltage = avg_r;
    res.phy_value   = job_r.phy_enable ? adcca_pkg::sat32(phy_wide) : '0;
    res.phy_valid   = job_r.phy_enable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      primed_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!job_empty) begin
            if (job.in_range && primed_r[in_idx]) begin
              state_r <= ST_LOAD;
            end else if (job.in_range && job.phy_enable) begin
              state_r <= ST_FILL;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_LOAD: state_r <= ST_PTR;
        ST_PTR:  state_r <= ST_UPD;
        ST_UPD:  state_r <= ST_DIV;
        ST_FILL: begin
          if (fill_last) begin
            primed_r[job_idx] <= 1'b1;
            state_r           <= ST_MUL;
          end
        end
        ST_DIV: begin
          if (div_last) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: state_r <= ST_OUT;
        ST_OUT: begin
          if (!res_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        job_r <= job;
        avg_r <= job.sample;
        cnt_r <= '0;
        sum_r <= '0;
      end
      ST_UPD: begin
        neg_r <= t_val[SUM_W-1];
        u_r   <= u_val;
        cnt_r <= '0;
      end
      ST_FILL: begin
        sum_r <= fill_sum;
        cnt_r <= cnt_r + 1'b1;
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (div_last) begin
          avg_r <= neg_r ? $signed(~quo) : $signed(quo);
        end else begin
          acc_r <= acc_nxt;
        end
      end
      ST_MUL: prod_r <= avg_r * job_r.phy_gain;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem_r[win_addr] <= job_r.sample;
    end
    if (win_re) begin
      win_rdata_r <= win_mem_r[win_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem_r[job_idx] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_r <= st_mem_r[job_idx];
    end
  end

endmodule

`default_nettype wire
